[rtl/core/assert_macros.svh]
// assertion macros, included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[rtl/core/itra_pkg.sv]
// package: sizes, control structs and the digit to ascii mapping
`default_nettype none

package itra_pkg;

  // number of value bits that are converted
  localparam int VALUE_WIDTH = 32;
  // width of the value port
  localparam int VALUE_PORT_W = 32;
  // decimal digits of the largest value: floor(w * log10(2)) + 1
  localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  // digit shift register, wide enough for the bcd form
  localparam int SR_W = 4 * DEC_DIGITS;
  localparam int BIN_SHIFT = SR_W - VALUE_WIDTH;
  localparam int HEX_SHIFT = SR_W - 4 * HEX_DIGITS;
  // counter holding up to VALUE_WIDTH
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int CHAR_W = 7;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_PAST_NINE = 7'd58;
  localparam logic [CHAR_W-1:0] LETTER_GAP = 7'd7;

  // base select codes, bit 1 wins over bit 0
  localparam int SEL_HEX_BIT = 1;
  localparam int SEL_DEC_BIT = 0;

  // load request from the controller to the digit emitter
  typedef struct packed {
    logic             load;
    logic             wide;
    logic [CNT_W-1:0] count;
  } emit_ctrl_t;

  // emitter status back to the controller
  typedef struct packed {
    logic busy;
  } emit_stat_t;

  // digit value to ascii character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    c = {3'b000, d} + ASCII_ZERO;
    if (c >= ASCII_PAST_NINE) begin
      c = c + LETTER_GAP;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/itra_dabble.sv]
// bit serial binary to bcd converter (shift and add three)
`default_nettype none

module itra_dabble (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [itra_pkg::VALUE_WIDTH-1:0] value_i,
  output logic [itra_pkg::SR_W-1:0]    bcd_o,
  output logic                         done_o
);
  import itra_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q;
  logic [SR_W-1:0]        bcd_q;
  logic [SR_W-1:0]        adj;
  logic [CNT_W-1:0]       cnt_q;
  logic                   run_q;
  logic                   done_q;

  // add three to every bcd digit of five or more
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // control: one value bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(VALUE_WIDTH);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // datapath: shift value msb into the bcd register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (run_q) begin
      bcd_q <= {adj[SR_W-2:0], bin_q[VALUE_WIDTH-1]};
      bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  assign bcd_o  = bcd_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[rtl/core/itra_emit.sv]
// digit emitter: shifts digits out msb first, drops leading zeros
`default_nettype none

module itra_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  itra_pkg::emit_ctrl_t            ctrl_i,
  input  logic [itra_pkg::SR_W-1:0]       data_i,
  output itra_pkg::emit_stat_t            stat_o,
  output logic                            strobe_o,
  output logic [itra_pkg::CHAR_W-1:0]     digit_char_o,
  output logic                            last_o
);
  import itra_pkg::*;

  logic [SR_W-1:0]   sr_q;
  logic              wide_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              seen_q;
  logic              run_q;
  logic              strobe_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic [3:0]        digit;
  logic              is_last;
  logic              emit;

  // current digit at the top of the shift register
  always_comb begin
    if (wide_q) begin
      digit = sr_q[SR_W-1 -: 4];
    end else begin
      digit = {3'b000, sr_q[SR_W-1]};
    end
    is_last = (cnt_q == CNT_W'(1));
    emit    = seen_q || (digit != 4'd0) || is_last;
  end

  // control and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else if (ctrl_i.load) begin
      run_q    <= 1'b1;
      cnt_q    <= ctrl_i.count;
      seen_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else if (run_q) begin
      strobe_q <= emit;
      seen_q   <= emit;
      cnt_q    <= cnt_q - CNT_W'(1);
      if (is_last) begin
        run_q <= 1'b0;
      end
    end else begin
      strobe_q <= 1'b0;
    end
  end

  // digit shift register and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sr_q   <= data_i;
      wide_q <= ctrl_i.wide;
    end else if (run_q) begin
      char_q <= digit_to_ascii(digit);
      last_q <= is_last;
      if (wide_q) begin
        sr_q <= {sr_q[SR_W-5:0], 4'b0000};
      end else begin
        sr_q <= {sr_q[SR_W-2:0], 1'b0};
      end
    end
  end

  assign stat_o.busy  = run_q;
  assign strobe_o     = strobe_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

[rtl/core/integer_to_radix_ascii_top.sv]
// top level: integer to ascii digits in base 2, 10 or 16
//
//   channel   handshake             payload
//   request   start_i / busy_o      value_i, base_select_i
//   result    strobe_o (one cycle)  digit_char_o, last_o
//
// binary and hex: one bit or hex digit per emit cycle
// decimal: the dabble unit runs shift-and-add-three over the value bits, then
// the bcd result is loaded into the emitter, which sends one digit per cycle
// leading zeros are shifted through like other digits but raise no strobe
// a new request is taken only once the last one has been emitted; reset clears
// the controller and the control flops of both units; the receiver cannot stall
`default_nettype none

module integer_to_radix_ascii_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [itra_pkg::VALUE_PORT_W-1:0] value_i,
  input  logic [1:0]                        base_select_i,
  output logic                              strobe_o,
  output logic [itra_pkg::CHAR_W-1:0]       digit_char_o,
  output logic                              last_o
);
  import itra_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  state_e                 state_d;
  logic                   accept;
  logic                   dab_start;
  logic                   dab_done;
  logic [SR_W-1:0]        bcd;
  logic [VALUE_WIDTH-1:0] value_m;
  logic [SR_W-1:0]        load_data;
  emit_ctrl_t             ectrl;
  emit_stat_t             estat;
  logic                   char_ok;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign value_m = value_i[VALUE_WIDTH-1:0];

  // request decode and emitter load selection
  always_comb begin
    state_d     = state_q;
    dab_start   = 1'b0;
    ectrl.load  = 1'b0;
    ectrl.wide  = 1'b0;
    ectrl.count = CNT_W'(VALUE_WIDTH);
    load_data   = SR_W'(value_m) << BIN_SHIFT;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (base_select_i[SEL_HEX_BIT]) begin
            ectrl.load  = 1'b1;
            ectrl.wide  = 1'b1;
            ectrl.count = CNT_W'(HEX_DIGITS);
            load_data   = SR_W'(value_m) << HEX_SHIFT;
            state_d     = ST_EMIT;
          end else if (base_select_i[SEL_DEC_BIT]) begin
            dab_start = 1'b1;
            state_d   = ST_DABBLE;
          end else begin
            ectrl.load = 1'b1;
            state_d    = ST_EMIT;
          end
        end
      end
      ST_DABBLE: begin
        if (dab_done) begin
          ectrl.load  = 1'b1;
          ectrl.wide  = 1'b1;
          ectrl.count = CNT_W'(DEC_DIGITS);
          load_data   = bcd;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!estat.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // binary to bcd for decimal requests
  itra_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .value_i (value_m),
    .bcd_o   (bcd),
    .done_o  (dab_done)
  );

  // digit serializer
  itra_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ectrl),
    .data_i       (load_data),
    .stat_o       (estat),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  // result character is a decimal digit or an upper case hex letter
  assign char_ok = ((digit_char_o >= ASCII_ZERO) && (digit_char_o < ASCII_PAST_NINE)) ||
                   ((digit_char_o >= ASCII_PAST_NINE + LETTER_GAP) &&
                    (digit_char_o < ASCII_PAST_NINE + LETTER_GAP + 7'd6));

  // checks
  `ASSERT_ON_CLK(a_accept_busy, clk_i, rst_ni, accept |=> busy_o)
  `ASSERT_ON_CLK(a_idle_strobe_last, clk_i, rst_ni, (!busy_o && strobe_o) |-> last_o)
  `ASSERT_ON_CLK(a_last_gap, clk_i, rst_ni, (strobe_o && last_o) |=> !strobe_o)
  `ASSERT_ON_CLK(a_char_range, clk_i, rst_ni, strobe_o |-> char_ok)
  `ASSERT_NEVER(a_emit_in_dabble, clk_i, rst_ni, (state_q == ST_DABBLE) && estat.busy)

endmodule

`default_nettype wire

[tb/sv/integer_to_radix_ascii_checker.sv]
// checker: predicts the digit characters of each request and compares the strobed results
module integer_to_radix_ascii_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_o,
  input  logic [itra_pkg::VALUE_PORT_W-1:0] value_i,
  input  logic [1:0]                        base_select_i,
  input  logic                              strobe_o,
  input  logic [itra_pkg::CHAR_W-1:0]       digit_char_o,
  input  logic                              last_o,
  output int                                mismatch_count,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import itra_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int MAX_SPELLED = 64;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  // characters still owed by the block, oldest first
  digit_t pending_digits[$];
  digit_t want;
  int     report_count;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    report_count   = 0;
  end

  // expand one request into its characters, most significant first
  function automatic void spell_digits(input logic [VALUE_PORT_W-1:0] value,
                                       input logic [1:0] sel);
    logic [63:0]       mask;
    logic [63:0]       v;
    logic [63:0]       radix;
    logic [3:0]        stack [MAX_SPELLED];
    int                n;
    logic [CHAR_W-1:0] c;
    digit_t            d;
    mask = (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
    v    = 64'(value) & mask;
    // bit 1 of the selector takes priority, so the spare code means hex
    if (sel[SEL_HEX_BIT]) begin
      radix = 64'd16;
    end else if (sel[SEL_DEC_BIT]) begin
      radix = 64'd10;
    end else begin
      radix = 64'd2;
    end
    n = 0;
    // zero still gives one digit
    do begin
      stack[n] = 4'(v % radix);
      v = v / radix;
      n++;
    end while (v != 0 && n < MAX_SPELLED);
    for (int k = n - 1; k >= 0; k--) begin
      c = {3'b000, stack[k]} + ASCII_ZERO;
      if (c >= ASCII_PAST_NINE) begin
        c = c + LETTER_GAP;
      end
      d.ch   = c;
      d.last = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  // compare strobed characters first, then record any new request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) begin
        if (pending_digits.size() == 0) begin
          mismatch_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: unexpected digit char=%0d last=%0b", $realtime,
                     digit_char_o, last_o);
          end
        end else begin
          want = pending_digits.pop_front();
          if (digit_char_o !== want.ch || last_o !== want.last) begin
            mismatch_count++;
            if (report_count < MAX_REPORTS) begin
              report_count++;
              $display("%0t: digit mismatch expected char=%0d last=%0b, got char=%0d last=%0b",
                       $realtime, want.ch, want.last, digit_char_o, last_o);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        spell_digits(value_i, base_select_i);
      end
      outstanding = pending_digits.size();
    end
  end

endmodule

[tb/sv/integer_to_radix_ascii_top_tb.sv]
// testbench top: clock, reset, request stimulus and verdict for the radix converter
module integer_to_radix_ascii_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itra_pkg::*;

  // base select codes
  localparam logic [1:0] BASE_BIN   = 2'd0;
  localparam logic [1:0] BASE_DEC   = 2'd1;
  localparam logic [1:0] BASE_HEX   = 2'd2;
  localparam logic [1:0] BASE_SPARE = 2'd3;

  localparam int ITEMS_PER_PHASE = 33;
  localparam int MAX_GAP         = 40;
  localparam int DRAIN_CYCLES    = 100;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [VALUE_PORT_W-1:0] value_i;
  logic [1:0]              base_select_i;
  logic                    strobe_o;
  logic [CHAR_W-1:0]       digit_char_o;
  logic                    last_o;
  int                      mismatch_count;
  int                      outstanding;
  int                      idle_pct;

  integer_to_radix_ascii_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .base_select_i (base_select_i),
    .strobe_o      (strobe_o),
    .digit_char_o  (digit_char_o),
    .last_o        (last_o)
  );

  integer_to_radix_ascii_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .base_select_i  (base_select_i),
    .strobe_o       (strobe_o),
    .digit_char_o   (digit_char_o),
    .last_o         (last_o),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // watchdog
  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hold one request until the block takes it, then idle per the current mix
  task automatic send_request(input logic [VALUE_PORT_W-1:0] v, input logic [1:0] b);
    bit accepted;
    int gap;
    start_i       = 1'b1;
    value_i       = v;
    base_select_i = b;
    accepted      = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = !busy_o;
    end
    @(negedge clk_i);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start_i       = 1'b0;
      value_i       = $urandom();
      base_select_i = 2'($urandom_range(0, 3));
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // stop sending until every owed character has come out
  task automatic wait_drained();
    start_i = 1'b0;
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
  endtask

  // value mix: full random, small, single bits, masks, near all-ones
  function automatic logic [VALUE_PORT_W-1:0] pick_value();
    logic [VALUE_PORT_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 255);
      1: v = 32'd1 << $urandom_range(0, 31);
      2: v = (32'd1 << $urandom_range(0, 31)) - 32'd1;
      3: v = ~32'($urandom_range(0, 15));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return BASE_BIN;
    end else if (r < 6) begin
      return BASE_DEC;
    end else if (r < 9) begin
      return BASE_HEX;
    end
    return BASE_SPARE;
  endfunction

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    value_i       = '0;
    base_select_i = BASE_BIN;
    idle_pct      = 17;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero and all-ones in every base, digit boundaries, spare code
    send_request(32'd0, BASE_BIN);
    send_request(32'd0, BASE_DEC);
    send_request(32'd0, BASE_HEX);
    send_request(32'd0, BASE_SPARE);
    send_request(32'hFFFF_FFFF, BASE_BIN);
    send_request(32'hFFFF_FFFF, BASE_DEC);
    send_request(32'hFFFF_FFFF, BASE_HEX);
    send_request(32'hFFFF_FFFF, BASE_SPARE);
    send_request(32'd1, BASE_BIN);
    send_request(32'd1, BASE_DEC);
    send_request(32'd1, BASE_HEX);
    send_request(32'd9, BASE_DEC);
    send_request(32'd10, BASE_DEC);
    send_request(32'd9, BASE_HEX);
    send_request(32'd10, BASE_HEX);
    send_request(32'd15, BASE_HEX);
    send_request(32'd16, BASE_HEX);
    send_request(32'd1_000_000_000, BASE_DEC);
    send_request(32'h8000_0000, BASE_BIN);
    send_request(32'hFEDC_BA98, BASE_SPARE);
    send_request(32'h0123_4567, BASE_HEX);
    send_request(32'hAAAA_5555, BASE_BIN);
    wait_drained();

    // random: light idling, heavy idling, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 88 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_request(pick_value(), pick_base());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/itra_pkg.sv
rtl/core/itra_dabble.sv
rtl/core/itra_emit.sv
rtl/core/integer_to_radix_ascii_top.sv
tb/sv/integer_to_radix_ascii_checker.sv
tb/sv/integer_to_radix_ascii_top_tb.sv
